// File: design/rdq_pkg.sv
// ============================================================================
// rdq_pkg
// Shared types, widths and codes for the ring deque unit.
// ============================================================================
`default_nettype none

package rdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int SUM_W = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [1:0]          rd_sel_t;

    localparam op_t OP_PUSH_BACK  = 3'd0;
    localparam op_t OP_PUSH_FRONT = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_READ       = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    localparam rd_sel_t RD_FRONT = 2'd0;
    localparam rd_sel_t RD_BACK  = 2'd1;
    localparam rd_sel_t RD_INDEX = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic    accept;
        logic    exec;
        rd_sel_t rd_sel;
        logic    cap_front;
        logic    cap_back;
        logic    load_out;
    } cmd_t;

endpackage

`default_nettype wire

// File: design/rdq_if.sv
// ============================================================================
// rdq_if
// Valid/ready channels for operation beats and result beats.
// ============================================================================
`default_nettype none

interface rdq_cmd_if
    import rdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [VAL_W-1:0]  value;
    logic [INDEX_W-1:0]       index;

    modport source (output valid, output op, output value, output index, input ready);
    modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface rdq_rsp_if
    import rdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [VAL_W-1:0]  front_value;
    logic signed [VAL_W-1:0]  back_value;
    logic signed [VAL_W-1:0]  read_value;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, output status, output front_value, output back_value,
                    output read_value, output fill_count, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input read_value, input fill_count, output ready);
endinterface

`default_nettype wire

// File: design/rdq_ram.sv
// ============================================================================
// rdq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module rdq_ram #(
    parameter int DATA_W    = 32,
    parameter int NUM_WORDS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(NUM_WORDS)-1:0] waddr,
    input  wire logic [DATA_W-1:0]            wdata,
    input  wire logic [$clog2(NUM_WORDS)-1:0] raddr,
    output logic      [DATA_W-1:0]            rdata
);

    logic [DATA_W-1:0] mem_reg [NUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: design/rdq_ctrl.sv
// ============================================================================
// rdq_ctrl
// Sequencer: executes one operation, then reads front, back and indexed
// entries through the single RAM read port and loads the result register.
// ============================================================================
`default_nettype none

module rdq_ctrl
    import rdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RFRONT = 3'd2;
    localparam logic [2:0] S_RBACK  = 3'd3;
    localparam logic [2:0] S_RIDX   = 3'd4;
    localparam logic [2:0] S_RLAST  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_FRONT;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RFRONT;
            end
            S_RFRONT:
            begin
                cmd.rd_sel = RD_FRONT;
                state_next = S_RBACK;
            end
            S_RBACK:
            begin
                cmd.rd_sel    = RD_BACK;
                cmd.cap_front = 1'b1;
                state_next    = S_RIDX;
            end
            S_RIDX:
            begin
                cmd.rd_sel   = RD_INDEX;
                cmd.cap_back = 1'b1;
                state_next   = S_RLAST;
            end
            S_RLAST:
            begin
                // hold the index address so read data stays put while stalled
                cmd.rd_sel   = RD_INDEX;
                cmd.load_out = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/rdq_dp.sv
// ============================================================================
// rdq_dp
// Datapath: head/tail pointers, fill count, slot RAM and result register.
// ============================================================================
`default_nettype none

module rdq_dp
    import rdq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    input  wire logic [OP_W-1:0]     in_op,
    input  wire logic [VAL_W-1:0]    in_value,
    input  wire logic [INDEX_W-1:0]  in_index,
    output logic [STATUS_W-1:0]      out_status,
    output logic [VAL_W-1:0]         out_front,
    output logic [VAL_W-1:0]         out_back,
    output logic [VAL_W-1:0]         out_read,
    output logic [FILL_W-1:0]        out_fill
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] to_word(input logic [DATA_WIDTH-1:0] d);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(d);
        return ext[VAL_W-1:0];
    endfunction

    // latched operation
    op_t                 op_reg;
    logic [VAL_W-1:0]    value_reg;
    logic [INDEX_W-1:0]  index_reg;

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    status_t             status_reg, status_next;

    logic [VAL_W-1:0]    front_reg;
    logic [VAL_W-1:0]    back_reg;

    logic                    ram_we;
    logic [PTR_W-1:0]        ram_waddr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic [PTR_W-1:0]        ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    logic [EXT_W-1:0]    value_ext;
    logic                is_full;
    logic                is_empty;
    logic                idx_hit;
    logic [SUM_W-1:0]    idx_sum;
    logic [SUM_W-1:0]    idx_wrap;
    logic [VAL_W-1:0]    rd_word;

    assign value_ext = EXT_W'(value_reg);
    assign ram_wdata = value_ext[DATA_WIDTH-1:0];
    assign is_full   = (held_reg == CNT_FULL);
    assign is_empty  = (held_reg == '0);
    assign idx_hit   = (CMP_W'(index_reg) < CMP_W'(held_reg));
    assign idx_sum   = SUM_W'(head_reg) + SUM_W'(index_reg);
    assign idx_wrap  = (idx_sum >= SUM_WRAP) ? idx_sum - SUM_WRAP : idx_sum;
    assign rd_word   = to_word(ram_rdata);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = tail_reg;
        if (cmd.exec)
        begin
            status_next = ST_OK;
            case (op_reg)
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = tail_reg;
                        tail_next = ptr_inc(tail_reg);
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ptr_dec(head_reg);
                        head_next = ptr_dec(head_reg);
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        head_next = ptr_inc(head_reg);
                        held_next = held_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        tail_next = ptr_dec(tail_reg);
                        held_next = held_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (!idx_hit)
                    begin
                        status_next = ST_RANGE;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FRONT: ram_raddr = head_reg;
            RD_BACK:  ram_raddr = ptr_dec(tail_reg);
            RD_INDEX: ram_raddr = idx_wrap[PTR_W-1:0];
            default:  ram_raddr = head_reg;
        endcase
    end

    rdq_ram #(
        .DATA_W    (DATA_WIDTH),
        .NUM_WORDS (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            held_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            held_reg   <= held_next;
            status_reg <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
            index_reg <= in_index;
        end
        if (cmd.cap_front)
        begin
            front_reg <= is_empty ? '0 : rd_word;
        end
        if (cmd.cap_back)
        begin
            back_reg <= is_empty ? '0 : rd_word;
        end
        if (cmd.load_out)
        begin
            out_status <= status_reg;
            out_front  <= front_reg;
            out_back   <= back_reg;
            out_read   <= (op_reg == OP_READ && status_reg == ST_OK) ? rd_word : '0;
            out_fill   <= FILL_W'(held_reg);
        end
    end

endmodule

`default_nettype wire

// File: design/ring_deque_unit.sv
// ============================================================================
// ring_deque_unit
// Fixed-capacity double-ended ring buffer with indexed read.
// ============================================================================
// Each operation beat (push back, push front, pop front, pop back, read at
// an index from the front) returns one result beat with status, front and
// back values, the indexed value and the fill count after the operation.
// A push into a full store is dropped (status full), a pop on an empty store
// is ignored (status empty), a read past the fill count returns 0 (status out
// of range); front and back read 0 while empty. The slots sit in a RAM with
// one read port, so after the operation executes the front, back and indexed
// entries are read one after another before the next operation is accepted,
// with the result registered on the way out so the next operation can be
// taken while that result waits. No clearing pass is needed after reset.
`default_nettype none

module ring_deque_unit
    import rdq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rdq_cmd_if.sink    cmd,
    rdq_rsp_if.source  rsp
);

    cmd_t             ctl;
    logic [VAL_W-1:0] front_w;
    logic [VAL_W-1:0] back_w;
    logic [VAL_W-1:0] read_w;

    rdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctl)
    );

    rdq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl),
        .in_op      (cmd.op),
        .in_value   ($unsigned(cmd.value)),
        .in_index   (cmd.index),
        .out_status (rsp.status),
        .out_front  (front_w),
        .out_back   (back_w),
        .out_read   (read_w),
        .out_fill   (rsp.fill_count)
    );

    assign rsp.front_value = $signed(front_w);
    assign rsp.back_value  = $signed(back_w);
    assign rsp.read_value  = $signed(read_w);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec || ctl.cap_front || ctl.cap_back) |-> !cmd.ready)
        else $error("operation accepted while sequencer busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.fill_count == FILL_W'(DEPTH)))
        else $error("full status with store not full");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.fill_count == '0) |->
            (rsp.front_value == '0 && rsp.back_value == '0 && rsp.read_value == '0))
        else $error("nonzero value reported from empty store");

    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> !ctl.load_out)
        else $error("result register loaded twice for one operation");

endmodule

`default_nettype wire

// File: verif/deque_checker.sv
// ============================================================================
// deque_checker
// Watches the operation and result channels of the ring deque unit.
// ============================================================================
// Every accepted operation beat runs through a shadow deque, which yields the
// result expected for that beat. Result beats are compared in order, one
// field at a time. The checker hands back a mismatch count and the number of
// results still outstanding.

module deque_checker
    import rdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rdq_cmd_if   cmd,
    rdq_rsp_if   rsp,
    output int   error_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] back_value;
        logic signed [VAL_W-1:0] read_value;
        logic [FILL_W-1:0]       fill_count;
    } deque_result_t;

    // shadow store; only live entries are ever read back
    logic [DATA_WIDTH-1:0] shadow_slots [DEPTH];
    int unsigned           head_idx;
    int unsigned           tail_idx;
    int unsigned           held_cnt;

    deque_result_t expected_q [$];

    function automatic deque_result_t apply_deque_op(op_t op, logic signed [VAL_W-1:0] value,
                                                     logic [INDEX_W-1:0] index);
        deque_result_t r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK:
                if (held_cnt >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_slots[tail_idx] = DATA_WIDTH'(value);
                    tail_idx = (tail_idx + 1) % DEPTH;
                    held_cnt++;
                end
            OP_PUSH_FRONT:
                if (held_cnt >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    shadow_slots[head_idx] = DATA_WIDTH'(value);
                    held_cnt++;
                end
            OP_POP_FRONT:
                if (held_cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    head_idx = (head_idx + 1) % DEPTH;
                    held_cnt--;
                end
            OP_POP_BACK:
                if (held_cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    held_cnt--;
                end
            OP_READ:
                if (index < held_cnt)
                    r.read_value = VAL_W'(shadow_slots[(head_idx + index) % DEPTH]);
                else
                    r.status = ST_RANGE;
            default:
                ;   // undefined codes leave the store alone
        endcase
        if (held_cnt > 0)
        begin
            r.front_value = VAL_W'(shadow_slots[head_idx]);
            r.back_value  = VAL_W'(shadow_slots[(tail_idx + DEPTH - 1) % DEPTH]);
        end
        r.fill_count = FILL_W'(held_cnt);
        return r;
    endfunction

    task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t exp_r;
        if (!rst_n)
        begin
            expected_q.delete();
            head_idx = 0;
            tail_idx = 0;
            held_cnt = 0;
            pending  = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                expected_q.insert(expected_q.size(),
                                  apply_deque_op(cmd.op, cmd.value, cmd.index));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no operation outstanding");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_q[0];
                    expected_q.delete(0);
                    check_field("status", VAL_W'(exp_r.status), VAL_W'(rsp.status));
                    check_field("front_value", exp_r.front_value, rsp.front_value);
                    check_field("back_value", exp_r.back_value, rsp.back_value);
                    check_field("read_value", exp_r.read_value, rsp.read_value);
                    check_field("fill_count", VAL_W'(exp_r.fill_count), VAL_W'(rsp.fill_count));
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the ring deque unit.
// ============================================================================
// A short directed run hits the empty and out-of-range cases, the value
// extremes and the undefined op codes; then random phases lean toward
// filling, draining or an even mix, with random gaps on the operation side
// and random stalls on the result side. Checking lives in deque_checker.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rdq_pkg::*;

    localparam int unsigned RANDOM_OPS  = 1550;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 20;

    localparam op_t OP_RSVD_FIRST = 3'd5;
    localparam op_t OP_RSVD_MID   = 3'd6;
    localparam op_t OP_RSVD_LAST  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} phase_mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;

    rdq_cmd_if cmd_ch ();
    rdq_rsp_if rsp_ch ();

    ring_deque_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    deque_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .error_count (fail_count),
        .pending     (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 39))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t rand_op(phase_mix_t mix);
        int unsigned r;
        int unsigned push_w;
        int unsigned pop_w;
        r = $urandom_range(0, 99);
        push_w = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 20 : 40;
        pop_w  = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 60 : 35;
        if (r < 3)
            return op_t'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        else if (r < 3 + push_w)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (r < 3 + push_w + pop_w)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        else
            return OP_READ;
    endfunction

    // valid stays high into the next beat when there is no gap
    task automatic send_op(op_t op, logic signed [VAL_W-1:0] value, logic [INDEX_W-1:0] index,
                           int unsigned gap);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.value <= value;
        cmd_ch.index <= index;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // result side: ready runs broken by stalls, sometimes a long clean stretch
    initial
    begin
        int unsigned run;
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = gap_cycles();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned len;
        bit          steady;
        bit          first_phase;
        phase_mix_t  mix;

        cmd_ch.valid <= 1'b0;
        cmd_ch.op    <= OP_PUSH_BACK;
        cmd_ch.value <= '0;
        cmd_ch.index <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store
        send_op(OP_POP_FRONT, rand_value(), 4'd0, gap_cycles());
        send_op(OP_POP_BACK, rand_value(), 4'd0, gap_cycles());
        send_op(OP_READ, rand_value(), 4'd0, gap_cycles());
        send_op(OP_READ, rand_value(), 4'd15, gap_cycles());
        send_op(OP_RSVD_FIRST, rand_value(), 4'd15, gap_cycles());
        send_op(OP_RSVD_MID, rand_value(), 4'd0, gap_cycles());
        send_op(OP_RSVD_LAST, rand_value(), 4'd7, gap_cycles());
        // a front push near the empty state wraps the head pointer
        send_op(OP_PUSH_BACK, VAL_MAX, 4'd0, gap_cycles());
        send_op(OP_PUSH_FRONT, VAL_MIN, 4'd0, gap_cycles());
        send_op(OP_PUSH_BACK, '0, 4'd0, gap_cycles());
        send_op(OP_PUSH_FRONT, '1, 4'd0, gap_cycles());
        send_op(OP_READ, rand_value(), 4'd0, gap_cycles());
        send_op(OP_READ, rand_value(), 4'd3, gap_cycles());
        send_op(OP_READ, rand_value(), 4'd4, gap_cycles());
        send_op(OP_READ, rand_value(), 4'd15, gap_cycles());
        send_op(OP_RSVD_FIRST, rand_value(), 4'd1, gap_cycles());
        send_op(OP_POP_FRONT, rand_value(), 4'd0, gap_cycles());
        send_op(OP_POP_BACK, rand_value(), 4'd0, gap_cycles());
        send_op(OP_POP_BACK, rand_value(), 4'd0, gap_cycles());
        send_op(OP_POP_FRONT, rand_value(), 4'd0, gap_cycles());
        send_op(OP_POP_BACK, rand_value(), 4'd0, gap_cycles());

        sent = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_OPS)
        begin
            mix    = phase_mix_t'($urandom_range(0, 2));
            len    = $urandom_range(40, 140);
            if (len > RANDOM_OPS - sent)
                len = RANDOM_OPS - sent;
            steady = ($urandom_range(0, 3) == 0);
            repeat (len)
            begin
                send_op(rand_op(mix), rand_value(), INDEX_W'($urandom_range(0, 15)),
                        steady ? 0 : gap_cycles());
                sent++;
            end
            if (first_phase || $urandom_range(0, 3) == 0)
                quiesce();
            first_phase = 1'b0;
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
design/rdq_pkg.sv
design/rdq_if.sv
design/rdq_ram.sv
design/rdq_ctrl.sv
design/rdq_dp.sv
design/ring_deque_unit.sv
verif/deque_checker.sv
verif/testbench.sv
